FILE: hdl/u8d_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 byte stream decoder.
package u8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEFT_W  = 3;
  localparam int unsigned CP_W    = 31;
  localparam int unsigned EXP_W   = 3;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned MAX_LEN = 6;
  localparam int unsigned CONT_W  = 6;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STRICT = 2'd1,
    ST_END    = 2'd2
  } status_t;

  // Number of leading one bits of a byte, from 0 to 8.
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    unique casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  // Payload bits of a leading byte whose length is 2 to 6.
  function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                   input logic [LEN_W-1:0] len);
    logic [CP_W-1:0] p;
    case (len)
      4'd2:    p = CP_W'(b[4:0]);
      4'd3:    p = CP_W'(b[3:0]);
      4'd4:    p = CP_W'(b[2:0]);
      4'd5:    p = CP_W'(b[1:0]);
      4'd6:    p = CP_W'(b[0]);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/u8d_ifs.sv
// Valid/ready channel interfaces for the decoder's byte input and code point output.
interface u8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8d_pkg::BYTE_W-1:0]    byte_in;
  logic [u8d_pkg::LEFT_W-1:0]    bytes_left;

  modport source (output valid, output byte_in, output bytes_left, input ready);
  modport sink   (input valid, input byte_in, input bytes_left, output ready);
endinterface

interface u8d_out_if;
  logic                          valid;
  logic                          ready;
  logic [u8d_pkg::CP_W-1:0]      code_point;
  u8d_pkg::status_t              status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

FILE: hdl/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder: input register, decode stage, result register.
// The decoder takes one byte per request and sustains one byte per cycle unless a result
// waits on a stalled output. A byte is captured in an input register and decoded from it
// against the sequence state; a result is then written into the result register once free.
// The single decode stage that updates the sequence length and the 31-bit accumulator
// sets this rate. Sequences of up to six bytes in the original UTF-8 form are decoded
// without overlong or surrogate checks; malformed bytes report a strict error and a
// leading byte with too few bytes left reports an unexpected end, and either error
// returns the decoder to idle.
module utf8_byte_stream_decoder (
  input  logic         clk,
  input  logic         rst_n,
  u8d_in_if.sink       in_chan,
  u8d_out_if.source    out_chan
);

  logic                            s_valid_r;
  logic [u8d_pkg::BYTE_W-1:0]      s_byte_r;
  logic [u8d_pkg::LEFT_W-1:0]      s_left_r;

  logic [u8d_pkg::EXP_W-1:0]       exp_r;
  logic [u8d_pkg::EXP_W-1:0]       exp_nxt;
  logic [u8d_pkg::CP_W-1:0]        acc_r;
  logic [u8d_pkg::CP_W-1:0]        acc_nxt;

  logic                            out_valid_r;
  logic [u8d_pkg::CP_W-1:0]        out_cp_r;
  u8d_pkg::status_t                out_st_r;

  logic                            emit;
  logic [u8d_pkg::CP_W-1:0]        emit_cp;
  u8d_pkg::status_t                emit_st;
  logic [u8d_pkg::LEN_W-1:0]       len;
  logic [u8d_pkg::CP_W-1:0]        acc_shift;
  logic                            out_free;
  logic                            s_adv;
  logic                            in_fire;

  always_comb begin
    emit      = 1'b0;
    emit_cp   = '0;
    emit_st   = u8d_pkg::ST_OK;
    exp_nxt   = exp_r;
    acc_nxt   = acc_r;
    len       = u8d_pkg::lead_len(s_byte_r);
    acc_shift = {acc_r[u8d_pkg::CP_W-u8d_pkg::CONT_W-1:0], s_byte_r[u8d_pkg::CONT_W-1:0]};
    if (exp_r == '0) begin
      if (!s_byte_r[u8d_pkg::BYTE_W-1]) begin
        emit    = 1'b1;
        emit_cp = u8d_pkg::CP_W'(s_byte_r);
      end else if (len == 4'd1 || len > u8d_pkg::LEN_W'(u8d_pkg::MAX_LEN)) begin
        emit    = 1'b1;
        emit_st = u8d_pkg::ST_STRICT;
      end else if ({1'b0, s_left_r} < len) begin
        emit    = 1'b1;
        emit_st = u8d_pkg::ST_END;
      end else begin
        acc_nxt = u8d_pkg::lead_payload(s_byte_r, len);
        exp_nxt = u8d_pkg::EXP_W'(len - 4'd1);
      end
    end else if (s_byte_r[7:6] != 2'b10) begin
      emit    = 1'b1;
      emit_st = u8d_pkg::ST_STRICT;
    end else if (exp_r == 3'd1) begin
      emit    = 1'b1;
      emit_cp = acc_shift;
    end else begin
      acc_nxt = acc_shift;
      exp_nxt = exp_r - 3'd1;
    end
    if (emit) begin
      exp_nxt = '0;
      acc_nxt = '0;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign s_adv    = s_valid_r && (!emit || out_free);
  assign in_chan.ready = !s_valid_r || s_adv;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_byte_r <= in_chan.byte_in;
      s_left_r <= in_chan.bytes_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
      acc_r <= '0;
    end else if (s_adv) begin
      exp_r <= exp_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s_adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && emit) begin
      out_cp_r <= emit_cp;
      out_st_r <= emit_st;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.code_point = out_cp_r;
  assign out_chan.status     = out_st_r;

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != u8d_pkg::ST_OK) |-> (out_cp_r == '0))
    else $error("Error result carries a nonzero code point.");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    exp_r < u8d_pkg::EXP_W'(u8d_pkg::MAX_LEN))
    else $error("Expected continuation count out of range.");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && emit) |=> (exp_r == '0 && acc_r == '0))
    else $error("Sequence state not cleared after a result.");

  a_stage_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s_valid_r) |-> s_adv)
    else $error("Request accepted over a held input register.");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s_adv && emit) |=> out_valid_r)
    else $error("Result lost between decode stage and result register.");

endmodule

FILE: verif/tb_utf8_byte_stream_decoder.sv
// Self-checking testbench for the UTF-8 byte stream decoder with random traffic and stalls.
module tb_utf8_byte_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_BYTES    = 1300;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned LONG_HOLD  = 60;
  localparam int unsigned IDLE_LIMIT = 1000;

  typedef struct {
    bit [u8d_pkg::BYTE_W-1:0] b;
    bit [u8d_pkg::LEFT_W-1:0] left;
    bit                       hold;
  } byte_req_t;

  typedef struct {
    logic [u8d_pkg::CP_W-1:0] code_point;
    u8d_pkg::status_t         status;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_if();
  u8d_out_if out_if();

  utf8_byte_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  byte_req_t   byte_q[$];
  cp_result_t  due_cps[$];
  logic [u8d_pkg::EXP_W-1:0] seq_left = '0;
  logic [u8d_pkg::CP_W-1:0]  cp_acc   = '0;
  int unsigned n_bytes     = 0;
  int unsigned n_errors    = 0;
  int unsigned cps_checked = 0;

  always #2 clk = ~clk;

  // Mirrors the decoder's sequence state and queues the result, if any, of one accepted byte.
  function automatic void decode_byte(input logic [u8d_pkg::BYTE_W-1:0] b,
                                      input logic [u8d_pkg::LEFT_W-1:0] left);
    int unsigned ones;
    bit          done;
    cp_result_t  r;
    ones = 0;
    done = 1'b0;
    r.code_point = '0;
    r.status = u8d_pkg::ST_OK;
    if (seq_left == '0) begin
      while (ones < 8 && b[7 - ones]) ones++;
      if (ones == 0) begin
        r.code_point = u8d_pkg::CP_W'(b);
        done = 1'b1;
      end else if (ones == 1 || ones > u8d_pkg::MAX_LEN) begin
        r.status = u8d_pkg::ST_STRICT;
        done = 1'b1;
      end else if (left < ones) begin
        r.status = u8d_pkg::ST_END;
        done = 1'b1;
      end else begin
        cp_acc = u8d_pkg::CP_W'(b) & ((31'd1 << (7 - ones)) - 31'd1);
        seq_left = u8d_pkg::EXP_W'(ones - 1);
      end
    end else if (b[7:6] != 2'b10) begin
      r.status = u8d_pkg::ST_STRICT;
      done = 1'b1;
    end else begin
      cp_acc = {cp_acc[u8d_pkg::CP_W-7:0], b[5:0]};
      seq_left = seq_left - 1'b1;
      if (seq_left == '0) begin
        r.code_point = cp_acc;
        done = 1'b1;
      end
    end
    if (done) begin
      seq_left = '0;
      cp_acc = '0;
      due_cps.insert(due_cps.size(), r);
    end
  endfunction

  task automatic push_byte(input bit [u8d_pkg::BYTE_W-1:0] b, input int unsigned left);
    byte_req_t req;
    req.b = b;
    req.left = u8d_pkg::LEFT_W'(left);
    req.hold = 1'b0;
    byte_q.insert(byte_q.size(), req);
    n_bytes++;
  endtask

  task automatic push_pause();
    byte_req_t req;
    req.b = '0;
    req.left = '0;
    req.hold = 1'b1;
    byte_q.insert(byte_q.size(), req);
  endtask

  function automatic bit [u8d_pkg::BYTE_W-1:0] lead_byte(input int unsigned len);
    bit [u8d_pkg::BYTE_W-1:0] prefix;
    bit [u8d_pkg::BYTE_W-1:0] payload;
    prefix = 8'hFF << (8 - len);
    payload = 8'($urandom) & ((8'd1 << (7 - len)) - 8'd1);
    return prefix | payload;
  endfunction

  function automatic bit [u8d_pkg::BYTE_W-1:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic bit [u8d_pkg::BYTE_W-1:0] bad_cont_byte();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(192, 255));
  endfunction

  // A whole sequence of the given length; each remaining count of a multi-byte sequence covers at least the rest of it.
  task automatic push_sequence(input int unsigned len);
    int unsigned extra;
    int unsigned rem;
    extra = $urandom_range(0, 3);
    if (len == 1) begin
      push_byte(8'($urandom_range(0, 127)), $urandom_range(0, 7));
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        rem = len - i + extra;
        if (rem > u8d_pkg::MAX_LEN) rem = u8d_pkg::MAX_LEN;
        if (i == 0 && $urandom_range(0, 19) == 0) rem = 7;
        push_byte(i == 0 ? lead_byte(len) : cont_byte(), rem);
      end
    end
  endtask

  task automatic push_broken(input int unsigned len);
    int unsigned good;
    good = $urandom_range(0, len - 2);
    push_byte(lead_byte(len), $urandom_range(len, 7));
    for (int unsigned i = 0; i < good; i++) push_byte(cont_byte(), $urandom_range(1, 6));
    push_byte(bad_cont_byte(), $urandom_range(0, 7));
  endtask

  always @(posedge clk) begin : drive_bytes
    byte_req_t   req;
    int unsigned send_gap;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.byte_in <= '0;
      in_if.bytes_left <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) decode_byte(in_if.byte_in, in_if.bytes_left);
      if (!(in_if.valid && !in_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (byte_q[0].hold) begin
          in_if.valid <= 1'b0;
          if (due_cps.size() == 0) void'(byte_q.pop_front());
        end else if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_if.valid <= 1'b0;
        end else begin
          req = byte_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.byte_in <= req.b;
          in_if.bytes_left <= req.left;
        end
      end
    end
  end

  always @(posedge clk) begin : check_cps
    cp_result_t  want;
    int unsigned stall_cnt;
    int unsigned hold_cnt;
    bit          held;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
      held = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_cps.size() == 0) begin
          $error("unexpected result: code_point %h, status %0d",
                 out_if.code_point, out_if.status);
          n_errors++;
        end else begin
          want = due_cps.pop_front();
          if (out_if.code_point !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, out_if.code_point);
            n_errors++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            n_errors++;
          end
        end
        cps_checked++;
      end
      if (!held && cps_checked >= 200) begin
        held = 1'b1;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned idle_cycles;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_utf8_byte_stream_decoder: FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit paused;
    int unsigned pick;
    paused = 1'b0;
    rst_n = 1'b0;

    push_byte(8'h00, 1);
    push_byte(8'h7F, 0);
    push_byte(8'h80, 3);
    push_byte(8'hBF, 6);
    push_byte(8'hFE, 6);
    push_byte(8'hFF, 7);
    push_byte(8'hC0, 1);
    push_byte(8'hFC, 0);
    push_byte(8'hDF, 2);
    push_byte(8'hBF, 1);
    push_byte(8'hFD, 7);
    for (int unsigned i = 0; i < 5; i++) push_byte(8'hBF, 5 - i);
    push_byte(8'hE0, 6);
    push_byte(8'h41, 5);
    push_byte(8'hC2, 2);
    push_byte(8'hC0, 1);
    push_pause();

    while (n_bytes < N_BYTES) begin
      if (!paused && n_bytes >= 700) begin
        paused = 1'b1;
        push_pause();
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) push_sequence($urandom_range(1, 6));
      else if (pick < 75) push_byte(lead_byte($urandom_range(2, 6)), $urandom_range(0, 1));
      else if (pick < 88) push_broken($urandom_range(2, 6));
      else push_byte(8'($urandom), $urandom_range(0, 7));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_if.valid || due_cps.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_utf8_byte_stream_decoder: PASS");
    end else begin
      $display("tb_utf8_byte_stream_decoder: FAIL");
    end
    $finish;
  end

endmodule
